FILE: rtl/kfq_pkg.sv
package kfq_pkg;

   // field widths of a transaction
   localparam int FUNC_W   = 3;
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // default queue depth
   localparam int DEFAULT_DEPTH = 16;

   // stream widths (tdata padded to whole bytes)
   localparam int REQ_USER_W = FUNC_W;
   localparam int REQ_DATA_W = KEY_W + HANDLE_W;
   localparam int RSP_USER_W = STATUS_W + 1;
   localparam int RSP_BITS   = HANDLE_W + KEY_W + 1 + FILL_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ENQUEUE = 3'd0,
      FUNC_DEQUEUE = 3'd1,
      FUNC_PEEK    = 3'd2,
      FUNC_LOOKUP  = 3'd3,
      FUNC_REMOVE  = 3'd4
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_NULL = 2'd3
   } status_type;

   // controller states
   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_EXEC = 1'b1
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

FILE: rtl/kfq_ctrl.sv
module kfq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output kfq_pkg::cmd_type  cmd
);

   kfq_pkg::state_type state_ff;
   kfq_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kfq_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         kfq_pkg::STATE_IDLE: begin
            // take a transaction once the result slot is free or draining
            req_tready  = !rsp_valid_ff || rsp_tready;
            cmd.capture = req_tvalid && req_tready;
            if (cmd.capture) begin
               state_in = kfq_pkg::STATE_EXEC;
            end
         end
         kfq_pkg::STATE_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = kfq_pkg::STATE_IDLE;
         end
         default: begin
            state_in = kfq_pkg::STATE_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/kfq_dp.sv
module kfq_dp #(
   parameter int DEPTH = kfq_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kfq_pkg::cmd_type                    cmd,
   input  logic [kfq_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [kfq_pkg::KEY_W-1:0]    req_key,
   input  logic [kfq_pkg::HANDLE_W-1:0]        req_handle,
   output logic [kfq_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_found,
   output logic [kfq_pkg::HANDLE_W-1:0]        rsp_handle,
   output logic signed [kfq_pkg::KEY_W-1:0]    rsp_key,
   output logic                                rsp_empty,
   output logic [kfq_pkg::FILL_W-1:0]          rsp_fill
);

   localparam int CW = $clog2(DEPTH + 1);

   // slot cells, head at index 0
   logic [kfq_pkg::KEY_W-1:0]    cell_key_ff [DEPTH];
   logic [kfq_pkg::KEY_W-1:0]    cell_key_in [DEPTH];
   logic [kfq_pkg::HANDLE_W-1:0] cell_hdl_ff [DEPTH];
   logic [kfq_pkg::HANDLE_W-1:0] cell_hdl_in [DEPTH];
   logic [kfq_pkg::KEY_W-1:0]    up_key [DEPTH];
   logic [kfq_pkg::HANDLE_W-1:0] up_hdl [DEPTH];
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;

   // captured transaction and match vector
   kfq_pkg::func_type            op_ff;
   logic [kfq_pkg::KEY_W-1:0]    key_ff;
   logic [kfq_pkg::HANDLE_W-1:0] hdl_ff;
   logic [DEPTH-1:0]             match_ff;
   logic [DEPTH-1:0]             match_in;

   // first-match decode
   logic [DEPTH-1:0]             thermo;
   logic [DEPTH-1:0]             first;
   logic                         hit;
   logic                         enq_ok;
   logic                         drop;
   logic [kfq_pkg::KEY_W-1:0]    sel_key;
   logic [kfq_pkg::HANDLE_W-1:0] sel_hdl;

   // result register
   logic [kfq_pkg::STATUS_W-1:0] status_ff;
   logic [kfq_pkg::STATUS_W-1:0] status_in;
   logic                         found_ff;
   logic                         found_in;
   logic [kfq_pkg::HANDLE_W-1:0] out_hdl_ff;
   logic [kfq_pkg::HANDLE_W-1:0] out_hdl_in;
   logic [kfq_pkg::KEY_W-1:0]    out_key_ff;
   logic [kfq_pkg::KEY_W-1:0]    out_key_in;
   logic                         empty_ff;
   logic                         empty_in;
   logic [kfq_pkg::FILL_W-1:0]   fill_ff;
   logic [kfq_pkg::FILL_W-1:0]   fill_in;

   // neighbour taps and match prefix per cell
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g < DEPTH - 1) begin : g_up
         assign up_key[g] = cell_key_ff[g+1];
         assign up_hdl[g] = cell_hdl_ff[g+1];
      end else begin : g_last
         assign up_key[g] = cell_key_ff[g];
         assign up_hdl[g] = cell_hdl_ff[g];
      end
      assign thermo[g] = |match_ff[g:0];
      if (g == 0) begin : g_head
         assign first[g] = match_ff[g];
      end else begin : g_rest
         assign first[g] = match_ff[g] && !thermo[g-1];
      end
   end

   // parallel compare of the incoming key against the live slots, or a pick of the head for dequeue and peek
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (req_func == kfq_pkg::FUNC_DEQUEUE || req_func == kfq_pkg::FUNC_PEEK) begin
            match_in[i] = (i == 0) && (count_ff != '0);
         end else begin
            match_in[i] = (CW'(i) < count_ff) && (cell_key_ff[i] == req_key);
         end
      end
   end

   // selected entry, and/or mux over the one-hot first match
   always_comb begin
      sel_key = '0;
      sel_hdl = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_key = sel_key | (cell_key_ff[i] & {kfq_pkg::KEY_W{first[i]}});
         sel_hdl = sel_hdl | (cell_hdl_ff[i] & {kfq_pkg::HANDLE_W{first[i]}});
      end
   end

   assign hit    = thermo[DEPTH-1];
   assign enq_ok = (op_ff == kfq_pkg::FUNC_ENQUEUE) && (hdl_ff != '0)
                   && (count_ff != CW'(DEPTH));
   assign drop   = hit && (op_ff == kfq_pkg::FUNC_DEQUEUE || op_ff == kfq_pkg::FUNC_REMOVE);

   // cell update: append at tail, close the gap on removal
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_key_in[i] = cell_key_ff[i];
         cell_hdl_in[i] = cell_hdl_ff[i];
         if (cmd.execute && drop && thermo[i]) begin
            cell_key_in[i] = up_key[i];
            cell_hdl_in[i] = up_hdl[i];
         end else if (cmd.execute && enq_ok && CW'(i) == count_ff) begin
            cell_key_in[i] = key_ff;
            cell_hdl_in[i] = hdl_ff;
         end
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.execute && enq_ok) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.execute && drop) begin
         count_in = count_ff - CW'(1);
      end
   end

   // result fields
   always_comb begin
      status_in  = kfq_pkg::STATUS_OK;
      found_in   = 1'b0;
      out_hdl_in = '0;
      out_key_in = '0;
      case (op_ff)
         kfq_pkg::FUNC_ENQUEUE: begin
            if (hdl_ff == '0) begin
               status_in = kfq_pkg::STATUS_NULL;
            end else if (count_ff == CW'(DEPTH)) begin
               status_in = kfq_pkg::STATUS_FULL;
            end
         end
         kfq_pkg::FUNC_DEQUEUE, kfq_pkg::FUNC_PEEK,
         kfq_pkg::FUNC_LOOKUP, kfq_pkg::FUNC_REMOVE: begin
            if (hit) begin
               found_in   = 1'b1;
               out_hdl_in = sel_hdl;
               out_key_in = sel_key;
            end else begin
               status_in = kfq_pkg::STATUS_MISS;
            end
         end
         default: begin
            status_in = kfq_pkg::STATUS_OK;
         end
      endcase
      empty_in = (count_in == '0);
      fill_in  = kfq_pkg::FILL_W'(count_in);
   end

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // slot cells
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_key_ff[i] <= cell_key_in[i];
         cell_hdl_ff[i] <= cell_hdl_in[i];
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= kfq_pkg::func_type'(req_func);
         key_ff   <= req_key;
         hdl_ff   <= req_handle;
         match_ff <= match_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         found_ff   <= found_in;
         out_hdl_ff <= out_hdl_in;
         out_key_ff <= out_key_in;
         empty_ff   <= empty_in;
         fill_ff    <= fill_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_handle = out_hdl_ff;
   assign rsp_key    = out_key_ff;
   assign rsp_empty  = empty_ff;
   assign rsp_fill   = fill_ff;

endmodule

FILE: rtl/keyed_fifo_queue_top.sv
// result: valid once the accepted request has been captured and its cell update has run in the execute state
// flow: capture and compare, then cell update, before the next transaction is taken;
//    a new request waits until any earlier result is taken, at the earliest in that cycle
// reset (synchronous): queue emptied and result channel cleared; slot contents
//    are left as they are and only read below the fill count
module keyed_fifo_queue_top #(
   parameter int DEPTH = kfq_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // search_key [31:0], entry_handle [63:32]
   input  logic [kfq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func [2:0]
   input  logic [kfq_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_handle [31:0], out_key [63:32], is_empty [64], fill_level [69:65], zero [71:70]
   output logic [kfq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status [1:0], found [2]
   output logic [kfq_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   kfq_pkg::cmd_type                 cmd;
   logic [kfq_pkg::STATUS_W-1:0]     status;
   logic                             found;
   logic [kfq_pkg::HANDLE_W-1:0]     out_handle;
   logic signed [kfq_pkg::KEY_W-1:0] out_key;
   logic                             is_empty;
   logic [kfq_pkg::FILL_W-1:0]       fill_level;

   // handshake controller
   kfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // slot cells and result register
   kfq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_func   (req_tuser[kfq_pkg::FUNC_W-1:0]),
      .req_key    (req_tdata[kfq_pkg::KEY_W-1:0]),
      .req_handle (req_tdata[kfq_pkg::KEY_W +: kfq_pkg::HANDLE_W]),
      .rsp_status (status),
      .rsp_found  (found),
      .rsp_handle (out_handle),
      .rsp_key    (out_key),
      .rsp_empty  (is_empty),
      .rsp_fill   (fill_level)
   );

   // result packing
   assign rsp_tdata = kfq_pkg::RSP_DATA_W'({fill_level, is_empty, out_key, out_handle});
   assign rsp_tuser = {found, status};

   // one transaction in flight: no new request right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in flight");

   // every accepted request gives a registered result after the capture and execute states
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##2 rsp_tvalid)
      else $error("result missing after accepted request");

   // a found entry always reports ok status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && found) |-> (status == kfq_pkg::STATUS_OK))
      else $error("found entry with failing status");

   // empty flag agrees with the fill level while the depth is below 32
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((DEPTH >= 32) || (is_empty == (fill_level == '0))))
      else $error("empty flag disagrees with fill level");

endmodule
